@@ sv/im2col_pkg.sv @@
package im2col_pkg;

   // default sizing of the counters
   localparam int MAX_DIM_DEFAULT    = 1024;
   localparam int MAX_KERNEL_DEFAULT = 255;

   // field widths
   localparam int ADDR_W     = 32;
   localparam int DIM_REG_W  = 11;
   localparam int PACK_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_DIMS = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_PADDING     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE      = 3'd7;

   // reset values
   localparam logic [DIM_REG_W-1:0] DIM_RESET    = 11'd1;
   localparam logic [PACK_W-1:0]    KERNEL_RESET = 16'h0101;
   localparam logic [PACK_W-1:0]    PAD_RESET    = 16'h0000;
   localparam logic [PACK_W-1:0]    STRIDE_RESET = 16'h0101;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [DIM_REG_W-1:0] in_width;
      logic [DIM_REG_W-1:0] in_height;
      logic [DIM_REG_W-1:0] channels;
      logic [DIM_REG_W-1:0] out_width;
      logic [DIM_REG_W-1:0] out_height;
      logic [PACK_W-1:0]    kernel_dims;
      logic [PACK_W-1:0]    padding;
      logic [PACK_W-1:0]    stride;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic mul1;
      logic mul2;
      logic mul3;
      logic load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

@@ sv/im2col_if.sv @@
interface im2col_req_if import im2col_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              restart;
   logic [ADDR_W-1:0] image_base;

   modport source (output valid, output restart, output image_base, input ready);
   modport sink (input valid, input restart, input image_base, output ready);
endinterface

interface im2col_rsp_if import im2col_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] element_address;
   logic              is_pad;
   logic              is_last;

   modport source (output valid, output element_address, output is_pad, output is_last,
                   input ready);
   modport sink (input valid, input element_address, input is_pad, input is_last,
                 output ready);
endinterface

@@ sv/im2col_address_generator.sv @@
// im2col address generator: each accepted request word yields one response word holding
// the source address of the next element of the im2col matrix (order: output row, output
// column, channel, kernel row, kernel column), or a pad flag with address zero when the
// tap falls outside the image; is_last marks the final element, after which the counters
// wrap, and restart begins the sequence again. A request passes through four registered
// steps (position times stride alongside channel times height, padding removal and row
// index, row index times width, then the address sum into the output register), and no
// new request is taken until the last step has loaded the previous one. A finished
// response waits in the output register while the next request is being worked on; the
// last step waits as long as that register is still held. Geometry is to be written over
// the APB port only while the block is idle, which the block itself does not enforce;
// registers sit at byte offsets 4*i.
module im2col_address_generator import im2col_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int MAX_KERNEL = MAX_KERNEL_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   im2col_req_if.sink            req_if,
   im2col_rsp_if.source          rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   assign req_if.ready = req_ready;

   // configuration registers
   im2col_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   im2col_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters and address arithmetic
   im2col_dp #(
      .MAX_DIM    (MAX_DIM),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_restart         (req_if.restart),
      .req_image_base      (req_if.image_base),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_element_address (rsp_if.element_address),
      .rsp_is_pad          (rsp_if.is_pad),
      .rsp_is_last         (rsp_if.is_last)
   );

endmodule

@@ sv/im2col_csr.sv @@
module im2col_csr import im2col_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IN_WIDTH:    cfg_in.in_width    = csr_pwdata[DIM_REG_W-1:0];
            REG_IN_HEIGHT:   cfg_in.in_height   = csr_pwdata[DIM_REG_W-1:0];
            REG_CHANNELS:    cfg_in.channels    = csr_pwdata[DIM_REG_W-1:0];
            REG_OUT_WIDTH:   cfg_in.out_width   = csr_pwdata[DIM_REG_W-1:0];
            REG_OUT_HEIGHT:  cfg_in.out_height  = csr_pwdata[DIM_REG_W-1:0];
            REG_KERNEL_DIMS: cfg_in.kernel_dims = csr_pwdata[PACK_W-1:0];
            REG_PADDING:     cfg_in.padding     = csr_pwdata[PACK_W-1:0];
            REG_STRIDE:      cfg_in.stride      = csr_pwdata[PACK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width    <= DIM_RESET;
         cfg_ff.in_height   <= DIM_RESET;
         cfg_ff.channels    <= DIM_RESET;
         cfg_ff.out_width   <= DIM_RESET;
         cfg_ff.out_height  <= DIM_RESET;
         cfg_ff.kernel_dims <= KERNEL_RESET;
         cfg_ff.padding     <= PAD_RESET;
         cfg_ff.stride      <= STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (reg_idx)
         REG_IN_WIDTH:    csr_prdata = CSR_DATA_W'(cfg_ff.in_width);
         REG_IN_HEIGHT:   csr_prdata = CSR_DATA_W'(cfg_ff.in_height);
         REG_CHANNELS:    csr_prdata = CSR_DATA_W'(cfg_ff.channels);
         REG_OUT_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.out_width);
         REG_OUT_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.out_height);
         REG_KERNEL_DIMS: csr_prdata = CSR_DATA_W'(cfg_ff.kernel_dims);
         REG_PADDING:     csr_prdata = CSR_DATA_W'(cfg_ff.padding);
         REG_STRIDE:      csr_prdata = CSR_DATA_W'(cfg_ff.stride);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

@@ sv/im2col_ctrl.sv @@
module im2col_ctrl import im2col_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_MUL3 = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // step through the address chain, wait in the last step for the output register
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/im2col_dp.sv @@
module im2col_dp import im2col_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int MAX_KERNEL = MAX_KERNEL_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic              req_restart,
   input  logic [ADDR_W-1:0] req_image_base,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_element_address,
   output logic              rsp_is_pad,
   output logic              rsp_is_last
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int LIM_W  = $clog2(MAX_DIM + 1);
   localparam int KCNT_W = $clog2(MAX_KERNEL);
   localparam int KLIM_W = $clog2(MAX_KERNEL + 1);
   localparam int POS_W  = CNT_W + BYTE_W + 1;
   localparam int CH_W   = CNT_W + LIM_W;
   localparam int RI_W   = ((CH_W > POS_W) ? CH_W : POS_W) + 1;
   localparam int PR_W   = RI_W + LIM_W;

   function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [LIM_W-1:0] r;
      if (v == '0) begin
         r = LIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = LIM_W'(MAX_DIM);
      end else begin
         r = LIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [KLIM_W-1:0] clamp_kernel(input logic [BYTE_W-1:0] v);
      logic [KLIM_W-1:0] r;
      if (v == '0) begin
         r = KLIM_W'(1);
      end else if (32'(v) > MAX_KERNEL) begin
         r = KLIM_W'(MAX_KERNEL);
      end else begin
         r = KLIM_W'(v);
      end
      return r;
   endfunction

   // effective geometry
   logic [LIM_W-1:0]  w_lim, h_lim, ch_lim, ow_lim, oh_lim;
   logic [KLIM_W-1:0] kw_lim, kh_lim;
   logic [BYTE_W-1:0] pad_v, pad_h, stride_y, stride_x;

   assign w_lim    = clamp_dim(cfg.in_width);
   assign h_lim    = clamp_dim(cfg.in_height);
   assign ch_lim   = clamp_dim(cfg.channels);
   assign ow_lim   = clamp_dim(cfg.out_width);
   assign oh_lim   = clamp_dim(cfg.out_height);
   assign kh_lim   = clamp_kernel(cfg.kernel_dims[PACK_W-1:BYTE_W]);
   assign kw_lim   = clamp_kernel(cfg.kernel_dims[BYTE_W-1:0]);
   assign pad_v    = cfg.padding[PACK_W-1:BYTE_W];
   assign pad_h    = cfg.padding[BYTE_W-1:0];
   assign stride_y = cfg.stride[PACK_W-1:BYTE_W];
   assign stride_x = cfg.stride[BYTE_W-1:0];

   // position counters
   logic [CNT_W-1:0]  orow_ff, orow_in, ocol_ff, ocol_in, chan_ff, chan_in;
   logic [KCNT_W-1:0] krow_ff, krow_in, kcol_ff, kcol_in;
   logic              wrap_kc, wrap_kr, wrap_ch, wrap_oc, wrap_or;

   assign wrap_kc = (KLIM_W + 1)'(kcol_ff) + (KLIM_W + 1)'(1) >= (KLIM_W + 1)'(kw_lim);
   assign wrap_kr = (KLIM_W + 1)'(krow_ff) + (KLIM_W + 1)'(1) >= (KLIM_W + 1)'(kh_lim);
   assign wrap_ch = (LIM_W + 1)'(chan_ff) + (LIM_W + 1)'(1) >= (LIM_W + 1)'(ch_lim);
   assign wrap_oc = (LIM_W + 1)'(ocol_ff) + (LIM_W + 1)'(1) >= (LIM_W + 1)'(ow_lim);
   assign wrap_or = (LIM_W + 1)'(orow_ff) + (LIM_W + 1)'(1) >= (LIM_W + 1)'(oh_lim);

   // restart clears on take, the nest advances as the first step reads it
   always_comb begin
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      chan_in = chan_ff;
      krow_in = krow_ff;
      kcol_in = kcol_ff;
      if (cmd.take && req_restart) begin
         orow_in = '0;
         ocol_in = '0;
         chan_in = '0;
         krow_in = '0;
         kcol_in = '0;
      end else if (cmd.mul1) begin
         kcol_in = wrap_kc ? '0 : kcol_ff + KCNT_W'(1);
         if (wrap_kc) begin
            krow_in = wrap_kr ? '0 : krow_ff + KCNT_W'(1);
            if (wrap_kr) begin
               chan_in = wrap_ch ? '0 : chan_ff + CNT_W'(1);
               if (wrap_ch) begin
                  ocol_in = wrap_oc ? '0 : ocol_ff + CNT_W'(1);
                  if (wrap_oc) begin
                     orow_in = wrap_or ? '0 : orow_ff + CNT_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orow_ff <= '0;
         ocol_ff <= '0;
         chan_ff <= '0;
         krow_ff <= '0;
         kcol_ff <= '0;
      end else begin
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         chan_ff <= chan_in;
         krow_ff <= krow_in;
         kcol_ff <= kcol_in;
      end
   end

   // input word capture
   logic [ADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         base_ff <= req_image_base;
      end
   end

   // step one: strided positions and channel plane offset
   logic [POS_W-1:0] pos_y_ff, pos_x_ff;
   logic [CH_W-1:0]  ch_h_ff;
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         pos_y_ff <= POS_W'(orow_ff) * POS_W'(stride_y) + POS_W'(krow_ff);
         pos_x_ff <= POS_W'(ocol_ff) * POS_W'(stride_x) + POS_W'(kcol_ff);
         ch_h_ff  <= CH_W'(chan_ff) * CH_W'(h_lim);
         last_ff  <= wrap_kc & wrap_kr & wrap_ch & wrap_oc & wrap_or;
      end
   end

   // step two: remove padding, bounds check, row index
   logic [POS_W-1:0] y_val, x_val, x_ff;
   logic [RI_W-1:0]  row_ff;
   logic             pad_y, pad_x, pad2_ff, last2_ff;

   assign y_val = pos_y_ff - POS_W'(pad_v);
   assign x_val = pos_x_ff - POS_W'(pad_h);
   assign pad_y = (pos_y_ff < POS_W'(pad_v)) || (y_val >= POS_W'(h_lim));
   assign pad_x = (pos_x_ff < POS_W'(pad_h)) || (x_val >= POS_W'(w_lim));

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         row_ff   <= RI_W'(ch_h_ff) + RI_W'(y_val);
         x_ff     <= x_val;
         pad2_ff  <= pad_y | pad_x;
         last2_ff <= last_ff;
      end
   end

   // step three: row index times width
   logic [PR_W-1:0]   prod_full;
   logic [ADDR_W-1:0] prod_ff;
   logic [POS_W-1:0]  x3_ff;
   logic              pad3_ff, last3_ff;

   assign prod_full = PR_W'(row_ff) * PR_W'(w_lim);

   always_ff @(posedge clock) begin
      if (cmd.mul3) begin
         prod_ff  <= ADDR_W'(prod_full);
         x3_ff    <= x_ff;
         pad3_ff  <= pad2_ff;
         last3_ff <= last2_ff;
      end
   end

   // final sum into the output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] addr_ff;
   logic              is_pad_ff, is_last_ff;

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff    <= pad3_ff ? '0 : prod_ff + ADDR_W'(x3_ff) + base_ff;
         is_pad_ff  <= pad3_ff;
         is_last_ff <= last3_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_element_address = addr_ff;
   assign rsp_is_pad          = is_pad_ff;
   assign rsp_is_last         = is_last_ff;

endmodule

@@ sv/im2col_checker.sv @@
module im2col_checker import im2col_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_element_address,
   input logic              rsp_is_pad,
   input logic              rsp_is_last
);

   logic req_take;

   assign req_take = req_valid & req_ready;

   // one word in flight: no second request right after an accepted one
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request accepted while the previous word is in flight");

   // a response cannot be produced in the cycle after its request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !$rose(rsp_valid))
      else $error("response appeared too early after request");

   // padded taps carry a zero address
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_pad) |-> (rsp_element_address == '0))
      else $error("padded word with a nonzero address");

   // stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_element_address) && $stable(rsp_is_pad)
          && $stable(rsp_is_last)))
      else $error("stalled response changed");

endmodule

bind im2col_address_generator im2col_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_element_address (rsp_if.element_address),
   .rsp_is_pad          (rsp_if.is_pad),
   .rsp_is_last         (rsp_if.is_last)
);

@@ tb/im2col_address_generator_tb.sv @@
module im2col_address_generator_tb import im2col_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned RANDOM_WORDS = 900;

   typedef struct packed {
      logic [ADDR_W-1:0] element_address;
      logic              is_pad;
      logic              is_last;
   } tap_type;

   // tracks the geometry and the five nested counters, predicts each tap address
   class tap_tracker;
      logic [PACK_W-1:0] geometry [8];
      int unsigned out_row, out_col, chan_index, kernel_row, kernel_col;
      tap_type expected_taps [$];
      int unsigned words_in, words_out, failures, pads_seen, lasts_seen;

      function new();
         set_register(REG_IN_WIDTH, DIM_RESET);
         set_register(REG_IN_HEIGHT, DIM_RESET);
         set_register(REG_CHANNELS, DIM_RESET);
         set_register(REG_OUT_WIDTH, DIM_RESET);
         set_register(REG_OUT_HEIGHT, DIM_RESET);
         set_register(REG_KERNEL_DIMS, KERNEL_RESET);
         set_register(REG_PADDING, PAD_RESET);
         set_register(REG_STRIDE, STRIDE_RESET);
      endfunction

      function void set_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_KERNEL_DIMS, REG_PADDING, REG_STRIDE: geometry[idx] = value[PACK_W-1:0];
            default: geometry[idx] = PACK_W'(value[DIM_REG_W-1:0]);
         endcase
      endfunction

      // zero counts as one, oversize saturates
      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void note_word(logic restart, logic [ADDR_W-1:0] image_base);
         int unsigned w, h, ch, ow, oh, kh, kw;
         longint stride_y, stride_x, pad_v, pad_h, y, x;
         longint unsigned full;
         bit wrap;
         tap_type t;
         w  = clamp(geometry[REG_IN_WIDTH], MAX_DIM_DEFAULT);
         h  = clamp(geometry[REG_IN_HEIGHT], MAX_DIM_DEFAULT);
         ch = clamp(geometry[REG_CHANNELS], MAX_DIM_DEFAULT);
         ow = clamp(geometry[REG_OUT_WIDTH], MAX_DIM_DEFAULT);
         oh = clamp(geometry[REG_OUT_HEIGHT], MAX_DIM_DEFAULT);
         kh = clamp(geometry[REG_KERNEL_DIMS][PACK_W-1:BYTE_W], MAX_KERNEL_DEFAULT);
         kw = clamp(geometry[REG_KERNEL_DIMS][BYTE_W-1:0], MAX_KERNEL_DEFAULT);
         pad_v    = geometry[REG_PADDING][PACK_W-1:BYTE_W];
         pad_h    = geometry[REG_PADDING][BYTE_W-1:0];
         stride_y = geometry[REG_STRIDE][PACK_W-1:BYTE_W];
         stride_x = geometry[REG_STRIDE][BYTE_W-1:0];
         words_in++;

         if (restart) begin
            out_row = 0;
            out_col = 0;
            chan_index = 0;
            kernel_row = 0;
            kernel_col = 0;
         end

         // source pixel of the current tap
         y = longint'(out_row) * stride_y - pad_v + longint'(kernel_row);
         x = longint'(out_col) * stride_x - pad_h + longint'(kernel_col);
         t.is_pad = !((y >= 0) && (x >= 0) && (y < longint'(h)) && (x < longint'(w)));
         t.element_address = '0;
         if (!t.is_pad) begin
            full = 64'(chan_index) * 64'(h) * 64'(w) + 64'(y) * 64'(w) + 64'(x)
                 + 64'(image_base);
            t.element_address = full[ADDR_W-1:0];
         end

         // counters past a shrunken limit count as finished
         t.is_last = (out_row + 1 >= oh) && (out_col + 1 >= ow) && (chan_index + 1 >= ch)
                  && (kernel_row + 1 >= kh) && (kernel_col + 1 >= kw);
         expected_taps.push_back(t);

         // step the nest, kernel column fastest
         wrap = (kernel_col + 1 >= kw);
         kernel_col = wrap ? 0 : kernel_col + 1;
         if (wrap) begin
            wrap = (kernel_row + 1 >= kh);
            kernel_row = wrap ? 0 : kernel_row + 1;
            if (wrap) begin
               wrap = (chan_index + 1 >= ch);
               chan_index = wrap ? 0 : chan_index + 1;
               if (wrap) begin
                  wrap = (out_col + 1 >= ow);
                  out_col = wrap ? 0 : out_col + 1;
                  if (wrap) begin
                     out_row = (out_row + 1 >= oh) ? 0 : out_row + 1;
                  end
               end
            end
         end
      endfunction

      function void check_word(logic [ADDR_W-1:0] element_address, logic is_pad,
                               logic is_last);
         tap_type e;
         words_out++;
         pads_seen += is_pad;
         lasts_seen += is_last;
         if (expected_taps.size() == 0) begin
            failures++;
            $error("response word with no request outstanding: address %h", element_address);
            return;
         end
         e = expected_taps.pop_front();
         if (element_address !== e.element_address) begin
            failures++;
            $error("element_address mismatch: expected %h, got %h",
                   e.element_address, element_address);
         end
         if (is_pad !== e.is_pad) begin
            failures++;
            $error("is_pad mismatch: expected %b, got %b", e.is_pad, is_pad);
         end
         if (is_last !== e.is_last) begin
            failures++;
            $error("is_last mismatch: expected %b, got %b", e.is_last, is_last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   im2col_req_if req_ch ();
   im2col_rsp_if rsp_ch ();

   tap_tracker tracker = new();
   int unsigned geometry_count;
   bit held_once;

   im2col_address_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // random gaps, with one quiet window on each side
   function automatic bit takes_break(int unsigned count);
      if (count >= 550 && count < 700) return 1'b0;
      return $urandom_range(0, 99) < 10;
   endfunction

   // apb write: setup then access, register lands on the access edge
   task automatic write_csr(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_geometry(int unsigned w, int unsigned h, int unsigned ch,
                                 int unsigned ow, int unsigned oh,
                                 logic [PACK_W-1:0] kernel, logic [PACK_W-1:0] pad,
                                 logic [PACK_W-1:0] stride);
      write_csr(REG_IN_WIDTH, w);
      write_csr(REG_IN_HEIGHT, h);
      write_csr(REG_CHANNELS, ch);
      write_csr(REG_OUT_WIDTH, ow);
      write_csr(REG_OUT_HEIGHT, oh);
      write_csr(REG_KERNEL_DIMS, kernel);
      write_csr(REG_PADDING, pad);
      write_csr(REG_STRIDE, stride);
      geometry_count++;
   endtask

   // wait for every response, then let the pipeline go quiet
   task automatic settle();
      while (tracker.expected_taps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one request word, return on the accepting edge
   task automatic send_word(logic restart, logic [ADDR_W-1:0] image_base);
      while (takes_break(tracker.words_in)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.restart    <= restart;
      req_ch.image_base <= image_base;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_word(restart, image_base);
   endtask

   task automatic random_phase();
      logic [ADDR_W-1:0] base;
      int unsigned n;
      bit first_restart;
      req_ch.valid <= 1'b0;
      settle();
      if ($urandom_range(0, 7) == 0) begin
         // anything the registers hold, about half of the sizes out of range
         apply_geometry($urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
         // small convolutions so the matrix end comes around often
         apply_geometry($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 3),
                        $urandom_range(1, 3), $urandom_range(1, 3),
                        {8'($urandom_range(1, 3)), 8'($urandom_range(1, 3))},
                        {8'($urandom_range(0, 2)), 8'($urandom_range(0, 2))},
                        {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))});
      end
      n = $urandom_range(20, 90);
      base = $urandom();
      first_restart = $urandom_range(0, 1);
      for (int unsigned i = 0; i < n; i++) begin
         send_word((i == 0) ? first_restart : ($urandom_range(0, 99) < 4),
                   ($urandom_range(0, 9) == 0) ? $urandom() : base);
      end
   endtask

   // stimulus
   initial begin
      int unsigned directed_words;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.restart    <= 1'b0;
      req_ch.image_base <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: every word is a one-element matrix
      send_word(1'b0, '0);
      send_word(1'b1, '1);
      send_word(1'b0, $urandom());

      // 3x3 kernel with padding, mixed strides
      req_ch.valid <= 1'b0;
      settle();
      apply_geometry(5, 4, 2, 3, 2, 16'h0303, 16'h0101, 16'h0102);
      for (int i = 0; i < 10; i++) send_word(i == 0, 32'h1000_0000);

      // zero sizes and zero stride, maximum padding: always a pad, always last
      req_ch.valid <= 1'b0;
      settle();
      apply_geometry(0, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 16'h0000);
      for (int i = 0; i < 3; i++) send_word(1'b0, $urandom());

      // oversize sizes, largest kernel and stride
      req_ch.valid <= 1'b0;
      settle();
      apply_geometry(2047, 2047, 2047, 2047, 2047, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_word(1'b1, '1);
      for (int i = 0; i < 3; i++) send_word(1'b0, $urandom());

      // shrink the geometry under running counters
      req_ch.valid <= 1'b0;
      settle();
      apply_geometry(3, 3, 1, 1, 1, 16'h0101, 16'h0000, 16'h0101);
      for (int i = 0; i < 3; i++) send_word(1'b0, $urandom());

      directed_words = tracker.words_in;
      while (tracker.words_in < directed_words + RANDOM_WORDS) random_phase();

      req_ch.valid <= 1'b0;
      while (tracker.expected_taps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words over %0d geometry settings",
               tracker.words_in, geometry_count);
      $display("responses seen: %0d, of which %0d pad taps and %0d matrix ends",
               tracker.words_out, tracker.pads_seen, tracker.lasts_seen);
      if (tracker.failures == 0 && tracker.words_out == tracker.words_in) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // response side: check each word, stall at random, one long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_word(rsp_ch.element_address, rsp_ch.is_pad, rsp_ch.is_last);
         end
         if (!held_once && tracker.words_in >= 400) begin
            held_once = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= !takes_break(tracker.words_out);
      end
   end

   // watchdog
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
